// File: design/chme_pkg.sv
`timescale 1ns / 1ps

package chme_pkg;

   localparam int KEY_W               = 64;
   localparam int VALUE_W             = 64;
   localparam int CSR_W               = 4;
   localparam int HASH_DIGIT_W        = 16;
   localparam int DEF_MAX_TABLE_BITS  = 8;
   localparam int DEF_POOL_ENTRIES    = 1024;

   localparam logic [KEY_W-1:0] GOLDEN_MUL       = 64'h61C8_8646_80B5_83EB;
   localparam logic [CSR_W-1:0] TABLE_BITS_RESET = 4'd8;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_DUP  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

endpackage

// File: design/chme_hash.sv
`timescale 1ns / 1ps

module chme_hash #(
   parameter int MAX_TABLE_BITS = chme_pkg::DEF_MAX_TABLE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start_i,
   input  logic [chme_pkg::KEY_W-1:0]     key_i,
   input  logic [chme_pkg::CSR_W-1:0]     table_bits_i,
   output logic                           done_o,
   output logic [MAX_TABLE_BITS-1:0]      bucket_o
);
   import chme_pkg::*;

   localparam int NUM_DIGITS = KEY_W / HASH_DIGIT_W;
   localparam int CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int SHIFT_W    = $clog2(KEY_W);
   localparam int TB_W       = CSR_W + 1;

   localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic [CNT_W-1:0]                  digit_ff;
   logic [KEY_W-1:0]                  acc_ff;
   logic [KEY_W-1:0]                  acc_in;
   logic [MAX_TABLE_BITS-1:0]         bucket_ff;
   logic [MAX_TABLE_BITS-1:0]         bucket_in;
   logic [HASH_DIGIT_W-1:0]           digit;
   logic [HASH_DIGIT_W+KEY_W-1:0]     prod;
   logic [SHIFT_W-1:0]                shamt;
   logic [KEY_W-1:0]                  partial;
   logic [TB_W-1:0]                   tb_ext;
   logic [TB_W-1:0]                   eff_bits;
   logic [TB_W-1:0]                   rshift;
   logic [MAX_TABLE_BITS-1:0]         top_bits;

   // one key digit times the constant per cycle, accumulated mod 2^64
   always_comb begin
      digit    = key_i[digit_ff*HASH_DIGIT_W +: HASH_DIGIT_W];
      prod     = digit * GOLDEN_MUL;
      shamt    = SHIFT_W'(digit_ff) * SHIFT_W'(HASH_DIGIT_W);
      partial  = prod[KEY_W-1:0] << shamt;
      acc_in   = acc_ff + partial;

      tb_ext = {1'b0, table_bits_i};
      if (tb_ext == '0) begin
         eff_bits = TB_W'(1);
      end else if (tb_ext > TB_W'(MAX_TABLE_BITS)) begin
         eff_bits = TB_W'(MAX_TABLE_BITS);
      end else begin
         eff_bits = tb_ext;
      end
      rshift    = TB_W'(MAX_TABLE_BITS) - eff_bits;
      top_bits  = acc_in[KEY_W-1 -: MAX_TABLE_BITS];
      bucket_in = top_bits >> rshift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         digit_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start_i) begin
            busy_ff  <= 1'b1;
            digit_ff <= '0;
         end else if (busy_ff) begin
            digit_ff <= digit_ff + 1'b1;
            if (digit_ff == LAST_DIGIT) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         if (digit_ff == LAST_DIGIT) begin
            bucket_ff <= bucket_in;
         end
      end
   end

   assign done_o   = done_ff;
   assign bucket_o = bucket_ff;

endmodule

// File: design/chained_hash_map_engine.sv
`timescale 1ns / 1ps

// Key/value map with separate chaining. A lookup or insert hashes the 64-bit key with a shared
// 16x64 multiply-accumulate unit, one 16-bit key digit a cycle (top table_bits bits of key times
// the golden-ratio constant pick the bucket), reads the bucket head, then walks the chain through
// the entry memory with a fetch state and a compare state per entry visited, comparing keys in one
// shared comparator; an insert of a new key adds a write state. A request therefore holds the
// block from its transfer until its response is loaded into the output register, and one request
// is processed at a time. A clear sweeps all 2^MAX_TABLE_BITS (256 by default) bucket-head
// entries, one entry a cycle; the same sweep runs after reset, during which no request is taken.
// table_bits may be written only while idle and should be changed only after a clear. Insert of
// a new key into a full pool answers status 3.
module chained_hash_map_engine #(
   parameter int MAX_TABLE_BITS = chme_pkg::DEF_MAX_TABLE_BITS,
   parameter int POOL_ENTRIES   = chme_pkg::DEF_POOL_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,   // key, value
   input  logic [1:0]                    req_tuser,   // req_type
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,   // value_out
   output logic [1:0]                    rsp_tuser,   // status
   input  logic                          csr_wr_en,
   input  logic [chme_pkg::CSR_W-1:0]    csr_wr_data  // table_bits
);
   import chme_pkg::*;

   localparam int BUCKETS = 1 << MAX_TABLE_BITS;
   localparam int LINK_W  = $clog2(POOL_ENTRIES + 1);
   localparam int ENTRY_AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

   typedef struct packed {
      logic [LINK_W-1:0]  next;
      logic [VALUE_W-1:0] value;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_LOAD,
      S_FETCH,
      S_CMP,
      S_WRITE,
      S_RESP
   } state_type;

   state_type                   state_ff;
   req_code_type                req_code_ff;
   logic [KEY_W-1:0]            key_ff;
   logic [VALUE_W-1:0]          value_ff;
   logic [CSR_W-1:0]            table_bits_ff;
   logic [LINK_W-1:0]           used_ff;
   logic [LINK_W-1:0]           ptr_ff;
   logic [MAX_TABLE_BITS-1:0]   clr_cnt_ff;
   logic                        clr_rsp_ff;
   status_type                  res_status_ff;
   logic [VALUE_W-1:0]          res_value_ff;
   logic                        rsp_valid_ff;
   status_type                  rsp_status_ff;
   logic [VALUE_W-1:0]          rsp_value_ff;
   logic                        hash_start;
   logic                        hash_done;
   logic [MAX_TABLE_BITS-1:0]   bucket;

   logic [LINK_W-1:0]           bucket_head_ff [BUCKETS];
   logic [LINK_W-1:0]           head_rd_ff;
   entry_type                   entry_ff [POOL_ENTRIES];
   entry_type                   entry_rd_ff;

   logic                        head_we;
   logic [MAX_TABLE_BITS-1:0]   head_waddr;
   logic [LINK_W-1:0]           head_wdata;
   logic                        entry_we;
   logic                        req_xfer;

   chme_hash #(
      .MAX_TABLE_BITS (MAX_TABLE_BITS)
   ) u_hash (
      .clock        (clock),
      .reset        (reset),
      .start_i      (hash_start),
      .key_i        (key_ff),
      .table_bits_i (table_bits_ff),
      .done_o       (hash_done),
      .bucket_o     (bucket)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_bits_ff <= TABLE_BITS_RESET;
      end else if (csr_wr_en) begin
         table_bits_ff <= csr_wr_data;
      end
   end

   // memory ports
   always_comb begin
      head_we    = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
      head_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : bucket;
      head_wdata = (state_ff == S_CLEAR) ? NIL : used_ff;
      entry_we   = (state_ff == S_WRITE);
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         bucket_head_ff[head_waddr] <= head_wdata;
      end
      head_rd_ff <= bucket_head_ff[bucket];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_ff[used_ff[ENTRY_AW-1:0]] <= '{next: head_rd_ff, value: value_ff, key: key_ff};
      end
      entry_rd_ff <= entry_ff[ptr_ff[ENTRY_AW-1:0]];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         hash_start   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == '1) begin
                  used_ff <= '0;
                  if (clr_rsp_ff) begin
                     res_status_ff <= ST_OK;
                     res_value_ff  <= '0;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_IDLE: begin
               if (req_xfer) begin
                  req_code_ff <= req_code_type'(req_tuser);
                  key_ff      <= req_tdata[KEY_W-1:0];
                  value_ff    <= req_tdata[KEY_W +: VALUE_W];
                  unique case (req_code_type'(req_tuser))
                     REQ_LOOKUP, REQ_INSERT: begin
                        hash_start <= 1'b1;
                        state_ff   <= S_HASH;
                     end
                     REQ_CLEAR: begin
                        clr_cnt_ff <= '0;
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= S_CLEAR;
                     end
                     default: begin
                        res_status_ff <= ST_OK;
                        res_value_ff  <= '0;
                        state_ff      <= S_RESP;
                     end
                  endcase
               end
            end
            S_HASH: begin
               hash_start <= 1'b0;
               if (hash_done) begin
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               ptr_ff   <= head_rd_ff;
               state_ff <= S_FETCH;
            end
            S_FETCH: begin
               if (ptr_ff < NIL) begin
                  state_ff <= S_CMP;
               end else begin
                  res_value_ff <= '0;
                  if (req_code_ff == REQ_LOOKUP) begin
                     res_status_ff <= ST_MISS;
                     state_ff      <= S_RESP;
                  end else if (used_ff == NIL) begin
                     res_status_ff <= ST_FULL;
                     state_ff      <= S_RESP;
                  end else begin
                     res_status_ff <= ST_OK;
                     state_ff      <= S_WRITE;
                  end
               end
            end
            S_CMP: begin
               if (entry_rd_ff.key == key_ff) begin
                  if (req_code_ff == REQ_LOOKUP) begin
                     res_status_ff <= ST_OK;
                     res_value_ff  <= entry_rd_ff.value;
                  end else begin
                     res_status_ff <= ST_DUP;
                     res_value_ff  <= '0;
                  end
                  state_ff <= S_RESP;
               end else begin
                  ptr_ff   <= entry_rd_ff.next;
                  state_ff <= S_FETCH;
               end
            end
            S_WRITE: begin
               used_ff  <= used_ff + 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  clr_rsp_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NIL)
      else $error("pool count beyond pool size");

   a_walk_in_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> $past(ptr_ff) < used_ff)
      else $error("chain link points outside the allocated pool");

   a_write_insert_only: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> req_code_ff == REQ_INSERT && used_ff < NIL)
      else $error("entry write outside a valid insert");

   a_hash_done_waited: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == S_HASH)
      else $error("hash finished with no request waiting for it");

endmodule

// File: test/tb_chained_hash_map_engine.sv
`timescale 1ns / 1ps

module tb_chained_hash_map_engine;
   import chme_pkg::*;

   localparam int POOL           = DEF_POOL_ENTRIES;
   localparam int BUCKETS        = 1 << DEF_MAX_TABLE_BITS;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      req_code_type      kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } map_request_type;

   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] value;
   } map_answer_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;     // key, value
   logic [1:0]    req_tuser = '0;     // req_type
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;          // value_out
   logic [1:0]    rsp_tuser;          // status
   logic          csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = TABLE_BITS_RESET;   // table_bits

   map_request_type  request_q[$];
   map_answer_type   answer_q[$];

   // shadow copy of the map
   logic [CSR_W-1:0]   shadow_bits = TABLE_BITS_RESET;
   int                 shadow_head [BUCKETS];
   logic [KEY_W-1:0]   shadow_key [POOL];
   logic [VALUE_W-1:0] shadow_val [POOL];
   int                 shadow_next [POOL];
   int                 shadow_used;

   int  send_gap = 0;
   int  recv_hold = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;

   chained_hash_map_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void empty_map();
      foreach (shadow_head[i]) shadow_head[i] = POOL;
      shadow_used = 0;
   endfunction

   function automatic int hash_bucket(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] prod;
      int bits;
      prod = key * GOLDEN_MUL;
      bits = shadow_bits;
      if (bits < 1) bits = 1;
      if (bits > DEF_MAX_TABLE_BITS) bits = DEF_MAX_TABLE_BITS;
      return int'(prod >> (KEY_W - bits)) & (BUCKETS - 1);
   endfunction

   function automatic int find_key(int bucket, logic [KEY_W-1:0] key);
      int p;
      int steps;
      p = shadow_head[bucket];
      steps = 0;
      while (p < POOL && steps < POOL) begin
         if (shadow_key[p] == key) return p;
         p = shadow_next[p];
         steps++;
      end
      return POOL;
   endfunction

   function automatic void predict_answer(req_code_type kind, logic [KEY_W-1:0] key,
                                          logic [VALUE_W-1:0] value);
      map_answer_type ans;
      int bucket;
      int hit;
      ans.status = ST_OK;
      ans.value  = '0;
      case (kind)
         REQ_LOOKUP: begin
            bucket = hash_bucket(key);
            hit = find_key(bucket, key);
            if (hit < POOL) ans.value = shadow_val[hit];
            else ans.status = ST_MISS;
         end
         REQ_INSERT: begin
            bucket = hash_bucket(key);
            hit = find_key(bucket, key);
            if (hit < POOL) begin
               ans.status = ST_DUP;
            end else if (shadow_used >= POOL) begin
               ans.status = ST_FULL;
            end else begin
               shadow_key[shadow_used]  = key;
               shadow_val[shadow_used]  = value;
               shadow_next[shadow_used] = shadow_head[bucket];
               shadow_head[bucket]      = shadow_used;
               shadow_used++;
            end
         end
         REQ_CLEAR: empty_map();
         default: ;
      endcase
      answer_q.push_back(ans);
   endfunction

   function automatic void queue_req(req_code_type kind, logic [KEY_W-1:0] key,
                                     logic [VALUE_W-1:0] value);
      map_request_type item;
      item.kind  = kind;
      item.key   = key;
      item.value = value;
      request_q.push_back(item);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_answer(req_code_type'(req_tuser), req_tdata[63:0], req_tdata[127:64]);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (request_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser  <= request_q[0].kind;
               req_tdata  <= {request_q[0].value, request_q[0].key};
               void'(request_q.pop_front());
               send_gap   <= idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected response status %0d value %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               if (rsp_tuser !== answer_q[0].status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, answer_q[0].status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== answer_q[0].value) begin
                  $display("%0t: value_out expected %h actual %h",
                           $time, answer_q[0].value, rsp_tdata);
                  mismatches++;
               end
               void'(answer_q.pop_front());
            end
         end
         if (recv_hold > 0) begin
            recv_hold  <= recv_hold - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            recv_hold  <= idle_len();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_chained_hash_map_engine failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (request_q.size() != 0 || req_tvalid || answer_q.size() != 0);
   endtask

   task automatic set_table_bits(input logic [CSR_W-1:0] bits);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= bits;
      shadow_bits = bits;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input logic [CSR_W-1:0] bits, input int count);
      logic [KEY_W-1:0] key_set [24];
      int r;
      int i;
      set_table_bits(bits);
      calm = ($urandom_range(0, 3) == 0);
      foreach (key_set[k]) key_set[k] = rand64();
      key_set[0] = '0;
      key_set[1] = '1;
      key_set[2] = 64'd1;
      queue_req(REQ_CLEAR, rand64(), rand64());
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            queue_req(REQ_INSERT, key_set[$urandom_range(0, 23)], rand64());
         else if (r < 45)
            queue_req(REQ_INSERT, rand64(), rand64());
         else if (r < 88)
            queue_req(REQ_LOOKUP, key_set[$urandom_range(0, 23)], rand64());
         else if (r < 93)
            queue_req(REQ_LOOKUP, rand64(), rand64());
         else if (r < 97)
            queue_req(REQ_NOP, rand64(), rand64());
         else
            queue_req(REQ_CLEAR, rand64(), rand64());
      end
   endtask

   initial begin
      logic [KEY_W-1:0] fill_keys [POOL];
      int i;

      empty_map();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed checks at the reset table size
      queue_req(REQ_LOOKUP, '0, '1);
      queue_req(REQ_INSERT, '0, '1);
      queue_req(REQ_INSERT, '0, 64'd5);
      queue_req(REQ_LOOKUP, '0, '0);
      queue_req(REQ_INSERT, '1, '0);
      queue_req(REQ_LOOKUP, '1, '1);
      queue_req(REQ_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
      queue_req(REQ_LOOKUP, 64'h8000_0000_0000_0000, '0);
      queue_req(REQ_NOP, '1, '1);
      queue_req(REQ_LOOKUP, 64'd1, '0);
      queue_req(REQ_CLEAR, '1, '1);
      queue_req(REQ_LOOKUP, '0, '0);
      queue_req(REQ_LOOKUP, '1, '0);
      queue_req(REQ_INSERT, '1, 64'h0123_4567_89AB_CDEF);
      queue_req(REQ_LOOKUP, '1, '0);
      queue_req(REQ_CLEAR, '0, '0);

      // fill the pool, then push past it
      set_table_bits(4'd8);
      queue_req(REQ_CLEAR, '0, '0);
      for (i = 0; i < POOL; i++) begin
         fill_keys[i] = rand64();
         queue_req(REQ_INSERT, fill_keys[i], rand64());
      end
      for (i = 0; i < 4; i++) queue_req(REQ_INSERT, rand64(), rand64());
      queue_req(REQ_INSERT, fill_keys[$urandom_range(0, POOL - 1)], rand64());
      for (i = 0; i < 20; i++)
         queue_req(REQ_LOOKUP, fill_keys[$urandom_range(0, POOL - 1)], rand64());

      // new table size over the old chains
      set_table_bits(4'd1);
      for (i = 0; i < 20; i++)
         queue_req(REQ_LOOKUP, fill_keys[$urandom_range(0, POOL - 1)], rand64());
      for (i = 0; i < 5; i++)
         queue_req(REQ_INSERT, fill_keys[$urandom_range(0, POOL - 1)], rand64());
      queue_req(REQ_INSERT, rand64(), rand64());

      random_phase(4'd1, 20);
      random_phase(4'd0, 20);
      random_phase(4'd15, 20);
      random_phase(4'd8, 20);
      random_phase(4'($urandom_range(1, 8)), 20);
      random_phase(4'd2, 20);
      random_phase(4'($urandom_range(0, 15)), 20);
      random_phase(4'd5, 20);

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("tb_chained_hash_map_engine passed");
      end else begin
         $display("tb_chained_hash_map_engine failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/chme_pkg.sv
design/chme_hash.sv
design/chained_hash_map_engine.sv
test/tb_chained_hash_map_engine.sv
